// File: rtl/rgrg_pkg.sv
package rgrg_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int RADIUS_W       = 17;
    localparam int COS_W          = 16;
    localparam int SIN_W          = 16;
    localparam int RECON_W        = 32;

endpackage

// File: rtl/rgrg_sqrt.sv
module rgrg_sqrt
    import rgrg_pkg::*;
#(
    parameter int MAG_W = 16,
    parameter int TAG_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2*MAG_W:0]     in_sq,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [MAG_W+1:0]     out_root,
    output logic [TAG_W-1:0]     out_tag
);

    localparam int SQ_W = 2 * MAG_W + 2;
    localparam int RT_W = MAG_W + 1;
    localparam int NS   = RT_W;

    logic [SQ_W-1:0]  rem_reg  [NS+1];
    logic [RT_W-1:0]  root_reg [NS+1];
    logic [SQ_W-1:0]  val_reg  [NS+1];
    logic [TAG_W-1:0] tag_reg  [NS+1];
    logic             vld_reg  [NS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            val_reg[0]  <= {1'b0, in_sq};
            tag_reg[0]  <= in_tag;
        end
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic [SQ_W-1:0] rem_next;
        logic [RT_W-1:0] root_next;
        always_comb begin
            rem_next  = {rem_reg[i][SQ_W-3:0], val_reg[i][SQ_W-1 -: 2]};
            root_next = {root_reg[i][RT_W-2:0], 1'b0};
            if (SQ_W'({root_reg[i], 2'b01}) <= rem_next) begin
                rem_next  = rem_next - SQ_W'({root_reg[i], 2'b01});
                root_next = {root_reg[i][RT_W-2:0], 1'b1};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
                val_reg[i+1]  <= {val_reg[i][SQ_W-3:0], 2'b00};
                tag_reg[i+1]  <= tag_reg[i];
            end
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_tag   = tag_reg[NS];
    assign out_root  = (rem_reg[NS] > SQ_W'(root_reg[NS])) ?
                       {1'b0, root_reg[NS]} + 1'b1 : {1'b0, root_reg[NS]};

endmodule

// File: rtl/rgrg_div.sv
module rgrg_div
    import rgrg_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 18,
    parameter int TAG_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] rem_reg [NUM_W+1];
    logic [NUM_W-1:0] num_reg [NUM_W+1];
    logic [DEN_W-1:0] den_reg [NUM_W+1];
    logic [TAG_W-1:0] tag_reg [NUM_W+1];
    logic             vld_reg [NUM_W+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            num_reg[0] <= in_num + NUM_W'(in_den >> 1);
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
        end
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_step
        logic [REM_W:0]   part;
        logic [REM_W-1:0] rem_next;
        logic [NUM_W-1:0] num_next;
        always_comb begin
            part     = {rem_reg[i], num_reg[i][NUM_W-1]};
            num_next = {num_reg[i][NUM_W-2:0], 1'b0};
            rem_next = part[REM_W-1:0];
            if (part >= (REM_W+1)'(den_reg[i])) begin
                rem_next    = REM_W'(part - (REM_W+1)'(den_reg[i]));
                num_next[0] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= rem_next;
                num_reg[i+1] <= num_next;
                den_reg[i+1] <= den_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_quo   = num_reg[NUM_W];
    assign out_tag   = tag_reg[NUM_W];

endmodule

// File: rtl/real_givens_rotation_generate_unit.sv
// Givens rotation generator: for each signed word pair (a, b) gives the integer radius r,
// c and s in Q2.FRAC_BITS and the reconstruction value z. Fully pipelined: one word
// accepted every cycle, but a result-side stall freezes the whole pipeline. It has input,
// squaring and output registers, (DATA_WIDTH+3) bit-per-stage square-root stages and
// (DATA_WIDTH+FRAC_BITS+4) stages in each of the three parallel restoring dividers.
module real_givens_rotation_generate_unit
    import rgrg_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [15:0]         s_a_value,
    input  logic signed [15:0]         s_b_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [RADIUS_W-1:0] m_radius,
    output logic signed [COS_W-1:0]    m_cosine,
    output logic signed [SIN_W-1:0]    m_sine,
    output logic signed [RECON_W-1:0]  m_recon
);

    localparam int MW  = DATA_WIDTH;
    localparam int RW  = MW + 2;
    localparam int NW  = RW + FRAC_BITS + 1;
    localparam int DW  = RW;
    localparam int TW1 = 2 * MW + 5;
    localparam int TW2 = 2 * RW + 4;

    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    logic [MW-1:0] a_raw, b_raw, a_mag, b_mag;
    logic          a_neg, b_neg;
    assign a_raw = MW'($unsigned(s_a_value));
    assign b_raw = MW'($unsigned(s_b_value));
    assign a_neg = a_raw[MW-1];
    assign b_neg = b_raw[MW-1];
    assign a_mag = a_neg ? (~a_raw + 1'b1) : a_raw;
    assign b_mag = b_neg ? (~b_raw + 1'b1) : b_raw;

    logic            v0_reg;
    logic [MW:0]     am0_reg, bm0_reg;
    logic            an0_reg, bn0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            am0_reg <= {a_neg && a_mag == '0, a_mag};
            bm0_reg <= {b_neg && b_mag == '0, b_mag};
            an0_reg <= a_neg;
            bn0_reg <= b_neg;
        end
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    logic [2*MW+1:0] asq_reg, bsq_reg;
    logic [MW:0]     am1_reg, bm1_reg;
    logic            an1_reg, bn1_reg, v1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            asq_reg <= (2*MW+2)'(am0_reg * am0_reg);
            bsq_reg <= (2*MW+2)'(bm0_reg * bm0_reg);
            am1_reg <= am0_reg;
            bm1_reg <= bm0_reg;
            an1_reg <= an0_reg;
            bn1_reg <= bn0_reg;
        end
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    logic [2*MW+2:0] sum;
    assign sum = (2*MW+3)'(asq_reg) + (2*MW+3)'(bsq_reg);

    logic            sq_v;
    logic [MW+2:0]   sq_root;
    logic [TW1-1:0]  sq_tag;
    rgrg_sqrt #(.MAG_W(MW + 1), .TAG_W(TW1)) u_sqrt (
        .aclk, .aresetn, .en,
        .in_valid  (v1_reg),
        .in_sq     (sum),
        .in_tag    ({an1_reg, bn1_reg, am1_reg, bm1_reg, 1'b0}),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    logic          t_an, t_bn, t_big_a, t_zero, t_rn;
    logic [MW:0]   t_am, t_bm;
    logic [DW-1:0] r_mag;
    assign {t_an, t_bn, t_am, t_bm} = sq_tag[TW1-1:1];
    assign r_mag   = DW'(sq_root);
    assign t_big_a = t_am > t_bm;
    assign t_zero  = t_am == '0 && t_bm == '0;
    assign t_rn    = t_big_a ? t_an : t_bn;

    logic [NW-1:0] c_num, s_num, z_num;
    logic [DW-1:0] rz_den, az_den;
    assign c_num  = NW'(t_am) << FRAC_BITS;
    assign s_num  = NW'(t_bm) << FRAC_BITS;
    assign z_num  = NW'(r_mag) << FRAC_BITS;
    assign rz_den = t_zero ? DW'(1) : r_mag;
    assign az_den = (t_am == '0) ? DW'(1) : DW'(t_am);

    logic [TW2-1:0] tg;
    assign tg = TW2'({t_zero, t_big_a, t_am == '0, t_rn, t_an != t_rn, t_bn != t_rn,
                      t_rn != t_an, r_mag});

    logic          dv_c, dv_s, dv_z;
    logic [NW-1:0] q_c, q_s, q_z;
    logic [TW2-1:0] tg_o, tg_s, tg_z;
    rgrg_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW2)) u_div_c (
        .aclk, .aresetn, .en, .in_valid(sq_v), .in_num(c_num), .in_den(rz_den),
        .in_tag(tg), .out_valid(dv_c), .out_quo(q_c), .out_tag(tg_o)
    );
    rgrg_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW2)) u_div_s (
        .aclk, .aresetn, .en, .in_valid(sq_v), .in_num(s_num), .in_den(rz_den),
        .in_tag(tg), .out_valid(dv_s), .out_quo(q_s), .out_tag(tg_s)
    );
    rgrg_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW2)) u_div_z (
        .aclk, .aresetn, .en, .in_valid(sq_v), .in_num(z_num), .in_den(az_den),
        .in_tag(tg), .out_valid(dv_z), .out_quo(q_z), .out_tag(tg_z)
    );

    logic          o_zero, o_biga, o_azero, o_rn, o_cn, o_sn, o_zn;
    logic [DW-1:0] o_r;
    assign {o_zero, o_biga, o_azero, o_rn, o_cn, o_sn, o_zn, o_r} = tg_o[DW+6:0];

    logic [63:0] c_val, s_val, r_val, zm, z_val;
    always_comb begin
        r_val = o_rn ? 64'd0 - 64'(o_r) : 64'(o_r);
        c_val = o_cn ? 64'd0 - 64'(q_c) : 64'(q_c);
        s_val = o_sn ? 64'd0 - 64'(q_s) : 64'(q_s);
        zm    = 64'(q_z);
        if (o_zn) begin
            if (zm > 64'h8000_0000) zm = 64'h8000_0000;
        end else begin
            if (zm > 64'h7FFF_FFFF) zm = 64'h7FFF_FFFF;
        end
        z_val = o_zn ? 64'd0 - zm : zm;
        if (o_zero) begin
            r_val = '0;
            c_val = 64'(1) << FRAC_BITS;
            s_val = '0;
            z_val = '0;
        end else if (o_biga) begin
            z_val = s_val;
        end else if (o_azero) begin
            z_val = 64'(1) << FRAC_BITS;
        end
    end

    logic                       out_v_reg;
    logic signed [RADIUS_W-1:0] radius_reg;
    logic signed [COS_W-1:0]    cosine_reg;
    logic signed [SIN_W-1:0]    sine_reg;
    logic signed [RECON_W-1:0]  recon_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            radius_reg <= RADIUS_W'(r_val);
            cosine_reg <= COS_W'(c_val);
            sine_reg   <= SIN_W'(s_val);
            recon_reg  <= RECON_W'(z_val);
        end
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= dv_c;
        end
    end
    assign m_valid  = out_v_reg;
    assign m_radius = radius_reg;
    assign m_cosine = cosine_reg;
    assign m_sine   = sine_reg;
    assign m_recon  = recon_reg;

    logic unused;
    assign unused = dv_s ^ dv_z ^ ^tg_s ^ ^tg_z ^ ^tg_o ^ ^sq_tag[0] ^ ^sq_root;

endmodule
